[hw/rtl/tlsrd_pkg.sv]
// Package for the TLS record deframer: result kinds, error codes, register
// indexes, header state encoding and the result beat structure.
// No dependencies.
package tlsrd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Header error codes
    localparam logic [1:0] ERR_TYPE    = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_FRAGMENT_LENGTH = 2'd0;
    localparam logic [1:0] REG_MIN_MINOR_VERSION   = 2'd1;
    localparam logic [1:0] REG_MAX_MINOR_VERSION   = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_MAX_FRAGMENT_LENGTH = 16'd18432;
    localparam logic [7:0]  RST_MIN_MINOR_VERSION   = 8'd1;
    localparam logic [7:0]  RST_MAX_MINOR_VERSION   = 8'd3;

    // Header checks: content types 20 to 23 share the upper six bits
    localparam logic [5:0] TYPE_HIGH_BITS = 6'd5;
    localparam logic [7:0] REQUIRED_MAJOR = 8'd3;

    // Next header byte expected, or payload phase
    typedef enum logic [5:0] {
        HDR_TYPE    = 6'b000001,
        HDR_MAJOR   = 6'b000010,
        HDR_MINOR   = 6'b000100,
        HDR_LEN_HI  = 6'b001000,
        HDR_LEN_LO  = 6'b010000,
        PAYLOAD     = 6'b100000
    } hdr_state_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  content_type;
        logic [7:0]  version_minor;
        logic [15:0] fragment_length;
        logic        last_of_record;
        logic [1:0]  error_code;
    } result_t;

endpackage

[hw/rtl/tls_record_deframer.sv]
// TLS record deframer top level: header parsing, checks and payload tagging.
// Depends on tlsrd_pkg.

// Takes the received record stream one byte per beat and emits each payload
// byte tagged with the record's content type, minor version and declared
// length, marking the last byte of the record. A record with a zero length
// gives one empty-record marker. When the fifth header byte arrives the type
// (20 to 23), version (major 3, minor within the configured bounds) and length
// (at most max_fragment_length) are checked in that order; the first failure
// gives one error beat and every later byte is consumed silently until reset.
// The header state and payload counter update in the cycle the byte is accepted
// and the result lands in the output or skid register, so a byte can be
// accepted every cycle while in_stall is low. A two-entry output buffer (output
// register plus skid register) keeps in_stall a registered signal; in_stall
// rises only when both entries are full. Configuration writes are taken in
// any cycle (cfg_ready is always high) and must be made while idle.
module tls_record_deframer
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              stream_byte,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [7:0]              payload_byte,
    output logic [7:0]              content_type,
    output logic [7:0]              version_minor,
    output logic [15:0]             fragment_length,
    output logic                    last_of_record,
    output logic [1:0]              error_code,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data
);
    import tlsrd_pkg::*;

    logic [15:0] max_fragment_length_reg;
    logic [7:0]  min_minor_version_reg;
    logic [7:0]  max_minor_version_reg;

    hdr_state_t  state_reg, state_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [7:0]  held_major_reg, held_major_next;
    logic [7:0]  held_minor_reg, held_minor_next;
    logic [7:0]  held_len_hi_reg, held_len_hi_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        stopped_reg, stopped_next;

    result_t     out_reg;
    logic        out_valid_reg;
    result_t     skid_reg;
    logic        skid_valid_reg;

    result_t     res;
    logic        res_produce;
    logic        in_accept;
    logic        out_take;
    logic [15:0] full_length;
    logic        type_bad;
    logic        version_bad;
    logic        length_bad;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fragment_length_reg <= RST_MAX_FRAGMENT_LENGTH;
            min_minor_version_reg   <= RST_MIN_MINOR_VERSION;
            max_minor_version_reg   <= RST_MAX_MINOR_VERSION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_FRAGMENT_LENGTH: max_fragment_length_reg <= cfg_data;
                REG_MIN_MINOR_VERSION:   min_minor_version_reg   <= cfg_data[7:0];
                REG_MAX_MINOR_VERSION:   max_minor_version_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake: stall only while the skid entry is occupied
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Header checks on the completed header
    assign full_length = {held_len_hi_reg, stream_byte};
    assign type_bad    = (held_type_reg[7:2] != TYPE_HIGH_BITS);
    assign version_bad = (held_major_reg != REQUIRED_MAJOR)
                      || (held_minor_reg < min_minor_version_reg)
                      || (held_minor_reg > max_minor_version_reg);
    assign length_bad  = (full_length > max_fragment_length_reg);

    // Advance the header state for one byte and build its result
    always_comb
    begin
        state_next           = state_reg;
        held_type_next       = held_type_reg;
        held_major_next      = held_major_reg;
        held_minor_next      = held_minor_reg;
        held_len_hi_next     = held_len_hi_reg;
        declared_length_next = declared_length_reg;
        remaining_next       = remaining_reg;
        stopped_next         = stopped_reg;
        res_produce          = 1'b0;

        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = 8'd0;
        res.content_type    = held_type_reg;
        res.version_minor   = held_minor_reg;
        res.fragment_length = declared_length_reg;
        res.last_of_record  = 1'b0;
        res.error_code      = ERR_TYPE;

        if (in_accept && !stopped_reg)
        begin
            unique case (state_reg)
                HDR_TYPE:
                begin
                    held_type_next = stream_byte;
                    state_next     = HDR_MAJOR;
                end
                HDR_MAJOR:
                begin
                    held_major_next = stream_byte;
                    state_next      = HDR_MINOR;
                end
                HDR_MINOR:
                begin
                    held_minor_next = stream_byte;
                    state_next      = HDR_LEN_HI;
                end
                HDR_LEN_HI:
                begin
                    held_len_hi_next = stream_byte;
                    state_next       = HDR_LEN_LO;
                end
                HDR_LEN_LO:
                begin
                    declared_length_next = full_length;
                    res.fragment_length  = full_length;
                    if (type_bad || version_bad || length_bad)
                    begin
                        // Report the first failing check, then drop everything
                        res_produce  = 1'b1;
                        res.kind     = KIND_ERROR;
                        stopped_next = 1'b1;
                        state_next   = HDR_TYPE;
                        if (type_bad)
                            res.error_code = ERR_TYPE;
                        else if (version_bad)
                            res.error_code = ERR_VERSION;
                        else
                            res.error_code = ERR_LENGTH;
                    end
                    else if (full_length == 16'd0)
                    begin
                        res_produce        = 1'b1;
                        res.kind           = KIND_EMPTY;
                        res.last_of_record = 1'b1;
                        remaining_next     = 16'd0;
                        state_next         = HDR_TYPE;
                    end
                    else
                    begin
                        remaining_next = full_length;
                        state_next     = PAYLOAD;
                    end
                end
                PAYLOAD:
                begin
                    if (remaining_reg != 16'd0)
                    begin
                        res_produce        = 1'b1;
                        res.kind           = KIND_PAYLOAD;
                        res.payload_byte   = stream_byte;
                        res.last_of_record = (remaining_reg == 16'd1);
                        remaining_next     = remaining_reg - 16'd1;
                        if (remaining_reg == 16'd1)
                            state_next = HDR_TYPE;
                    end
                    else
                    begin
                        // Nothing left: the byte opens a new header
                        held_type_next = stream_byte;
                        state_next     = HDR_MAJOR;
                    end
                end
                default:
                begin
                    state_next = HDR_TYPE;
                end
            endcase
        end
    end

    // Header state and record counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= HDR_TYPE;
            held_type_reg       <= 8'd0;
            held_major_reg      <= 8'd0;
            held_minor_reg      <= 8'd0;
            held_len_hi_reg     <= 8'd0;
            declared_length_reg <= 16'd0;
            remaining_reg       <= 16'd0;
            stopped_reg         <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            held_type_reg       <= held_type_next;
            held_major_reg      <= held_major_next;
            held_minor_reg      <= held_minor_next;
            held_len_hi_reg     <= held_len_hi_next;
            declared_length_reg <= declared_length_next;
            remaining_reg       <= remaining_next;
            stopped_reg         <= stopped_next;
        end
    end

    // Output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                // Refill from the skid entry; no beat enters this cycle
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_produce;
            end
        end
        else if (res_produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= res;
        end
        else if (res_produce)
        begin
            skid_reg <= res;
        end
    end

    // Drive the result ports
    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign payload_byte    = out_reg.payload_byte;
    assign content_type    = out_reg.content_type;
    assign version_minor   = out_reg.version_minor;
    assign fragment_length = out_reg.fragment_length;
    assign last_of_record  = out_reg.last_of_record;
    assign error_code      = out_reg.error_code;

endmodule

[tb/sv/tls_record_deframer_test.sv]
// Self-checking testbench for tls_record_deframer: a scoreboard class predicts
// each result beat from the accepted stream bytes and the register settings.
// Depends on tlsrd_pkg and the tls_record_deframer RTL.
module tls_record_deframer_test;

    import tlsrd_pkg::*;

    localparam int LIMIT         = 200000;
    localparam int SETTLE_CYCLES = 8;

    // Result beat fields that hold zero when they do not apply
    localparam logic [1:0] NO_ERROR   = 2'd0;
    localparam logic [7:0] NO_PAYLOAD = 8'd0;

    // Accepted content types
    localparam logic [7:0] TYPE_FIRST = 8'd20;
    localparam logic [7:0] TYPE_LAST  = 8'd23;

    // Register index outside the map; the block must ignore writes to it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum {
        BAD_TYPE,
        BAD_MAJOR,
        MINOR_OUT,
        MINOR_BOUNDS_CROSSED,
        TOO_LONG
    } header_fault_t;

    // Predicts deframer results and checks the beats that come out
    class deframe_scoreboard;
        result_t     pending[$];
        logic [15:0] max_len;
        logic [7:0]  lo_minor;
        logic [7:0]  hi_minor;
        hdr_state_t  pos;
        logic [7:0]  h_type;
        logic [7:0]  h_major;
        logic [7:0]  h_minor;
        logic [7:0]  h_len_hi;
        logic [15:0] decl_len;
        logic [15:0] remaining;
        bit          halted;
        int          mismatches;
        int          results_seen;
        int          bytes_seen;
        int          errors_seen;
        logic [1:0]  last_error;

        function new();
            max_len   = RST_MAX_FRAGMENT_LENGTH;
            lo_minor  = RST_MIN_MINOR_VERSION;
            hi_minor  = RST_MAX_MINOR_VERSION;
            pos       = HDR_TYPE;
            h_type    = '0;
            h_major   = '0;
            h_minor   = '0;
            h_len_hi  = '0;
            decl_len  = '0;
            remaining = '0;
            halted    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_MAX_FRAGMENT_LENGTH: max_len  = data;
                REG_MIN_MINOR_VERSION:   lo_minor = data[7:0];
                REG_MAX_MINOR_VERSION:   hi_minor = data[7:0];
                default: ;
            endcase
        endfunction

        function result_t build(logic [1:0] k, logic [7:0] pbyte, logic last,
                                logic [1:0] code);
            result_t r;
            r.kind            = k;
            r.payload_byte    = pbyte;
            r.content_type    = h_type;
            r.version_minor   = h_minor;
            r.fragment_length = decl_len;
            r.last_of_record  = last;
            r.error_code      = code;
            return r;
        endfunction

        // Advance the header/payload state by one accepted byte
        function void note_byte(logic [7:0] b);
            logic [1:0] code;
            bit         failed;
            bytes_seen++;
            if (halted)
                return;
            if (pos == PAYLOAD)
            begin
                if (remaining != 0)
                begin
                    remaining--;
                    pending.push_back(build(KIND_PAYLOAD, b, remaining == 0, NO_ERROR));
                    if (remaining == 0)
                        pos = HDR_TYPE;
                    return;
                end
                pos = HDR_TYPE;
            end
            case (pos)
                HDR_TYPE:
                begin
                    h_type = b;
                    pos    = HDR_MAJOR;
                    return;
                end
                HDR_MAJOR:
                begin
                    h_major = b;
                    pos     = HDR_MINOR;
                    return;
                end
                HDR_MINOR:
                begin
                    h_minor = b;
                    pos     = HDR_LEN_HI;
                    return;
                end
                HDR_LEN_HI:
                begin
                    h_len_hi = b;
                    pos      = HDR_LEN_LO;
                    return;
                end
                default: ;
            endcase
            // Last header byte: run type, version and length checks in order
            decl_len = {h_len_hi, b};
            failed   = 1;
            code     = NO_ERROR;
            if (!(h_type inside {[TYPE_FIRST:TYPE_LAST]}))
                code = ERR_TYPE;
            else if (h_major != REQUIRED_MAJOR || h_minor < lo_minor || h_minor > hi_minor)
                code = ERR_VERSION;
            else if (decl_len > max_len)
                code = ERR_LENGTH;
            else
                failed = 0;
            if (failed)
            begin
                halted = 1;
                pos    = HDR_TYPE;
                pending.push_back(build(KIND_ERROR, NO_PAYLOAD, 1'b0, code));
                return;
            end
            if (decl_len == 0)
            begin
                pos       = HDR_TYPE;
                remaining = '0;
                pending.push_back(build(KIND_EMPTY, NO_PAYLOAD, 1'b1, NO_ERROR));
                return;
            end
            remaining = decl_len;
            pos       = PAYLOAD;
        endfunction

        function void flag(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s: want kind %0d byte %02h type %0d minor %0d len %0d last %0d err %0d",
                         what, want.kind, want.payload_byte, want.content_type,
                         want.version_minor, want.fragment_length, want.last_of_record,
                         want.error_code);
                $display("    got kind %0d byte %02h type %0d minor %0d len %0d last %0d err %0d",
                         got.kind, got.payload_byte, got.content_type,
                         got.version_minor, got.fragment_length, got.last_of_record,
                         got.error_code);
            end
        endfunction

        // Compare one accepted result beat with the oldest prediction
        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (got.kind == KIND_ERROR)
            begin
                errors_seen++;
                last_error = got.error_code;
            end
            if (pending.size() == 0)
            begin
                flag("unexpected beat", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.content_type !== want.content_type ||
                got.version_minor !== want.version_minor ||
                got.fragment_length !== want.fragment_length ||
                got.last_of_record !== want.last_of_record ||
                got.error_code !== want.error_code)
                flag("mismatch", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  content_type;
    logic [7:0]  version_minor;
    logic [15:0] fragment_length;
    logic        last_of_record;
    logic [1:0]  error_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    deframe_scoreboard sb;
    bit                steady;
    int                cycle_count;
    int                records_sent;
    int                cur_mf;
    int                cur_lo;
    int                cur_hi;
    header_fault_t     fault;

    tls_record_deframer dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .stream_byte     (stream_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .content_type    (content_type),
        .version_minor   (version_minor),
        .fragment_length (fragment_length),
        .last_of_record  (last_of_record),
        .error_code      (error_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Stall the result side at random except during the steady stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !steady && ($urandom_range(99) < 23);
        end
    end

    // Check result beats and guard against a hang
    always @(posedge clk)
    begin
        result_t beat;
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            beat = {kind, payload_byte, content_type, version_minor, fragment_length,
                    last_of_record, error_code};
            sb.check_result(beat);
        end
    end

    // Send one stream beat, idling first at random; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_header(input logic [7:0] ctype, input logic [7:0] major,
                               input logic [7:0] minor, input logic [15:0] len);
        send_byte(ctype);
        send_byte(major);
        send_byte(minor);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_record(input logic [7:0] ctype, input logic [7:0] major,
                               input logic [7:0] minor, input logic [15:0] len);
        send_header(ctype, major, minor, len);
        for (int i = 0; i < int'(len); i++)
            send_byte(8'($urandom_range(255)));
        records_sent++;
    endtask

    // Well-formed records with random type, minor version and short lengths
    task automatic random_records(input int budget, input int cap);
        int sent;
        int lim;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            lim = (cur_mf < cap) ? cur_mf : cap;
            len = ($urandom_range(99) < 15) ? 0 : $urandom_range(lim);
            send_record(8'(TYPE_FIRST + $urandom_range(3)), REQUIRED_MAJOR,
                        8'($urandom_range(cur_lo, cur_hi)), 16'(len));
            sent += 5 + len;
        end
    endtask

    // Hold the sender until every predicted beat is out, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input int mf, input int lo, input int hi, input bit stray);
        write_reg(REG_MAX_FRAGMENT_LENGTH, 16'(mf));
        write_reg(REG_MIN_MINOR_VERSION, 16'(lo));
        write_reg(REG_MAX_MINOR_VERSION, 16'(hi));
        if (stray)
            write_reg(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
        cfg_valid <= 1'b0;
        @(negedge clk);
        cur_mf = mf;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    initial
    begin
        int         lo;
        int         hi;
        int         mf;
        logic [7:0] ctype;
        logic [7:0] major;
        logic [7:0] minor;
        int         len;

        sb           = new();
        steady       = 0;
        cycle_count  = 0;
        records_sent = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        stream_byte  = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cur_mf       = RST_MAX_FRAGMENT_LENGTH;
        cur_lo       = RST_MIN_MINOR_VERSION;
        cur_hi       = RST_MAX_MINOR_VERSION;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: empty record, one-byte and two-byte records, then random
        send_record(TYPE_FIRST, REQUIRED_MAJOR, 8'd1, 16'd0);
        send_record(TYPE_LAST, REQUIRED_MAJOR, 8'd3, 16'd1);
        send_record(TYPE_FIRST + 8'd1, REQUIRED_MAJOR, 8'd2, 16'd2);
        random_records(30, 24);
        drain_results();

        // Zero maximum length: only empty records pass, any minor version
        configure(0, 0, 255, 1);
        random_records(15, 24);
        drain_results();

        // Widest length, minor pinned at zero, no idling on either side
        steady = 1;
        configure(65535, 0, 0, 0);
        send_record(TYPE_FIRST + 8'd2, REQUIRED_MAJOR, 8'd0, 16'd260);
        drain_results();
        random_records(30, 40);
        steady = 0;
        drain_results();

        // Minor pinned at its top value, short maximum length
        configure(24, 255, 255, 0);
        random_records(20, 24);
        drain_results();

        // Random settings
        lo = $urandom_range(255);
        configure($urandom_range(1, 65535), lo, $urandom_range(lo, 255), 1);
        random_records(25, 24);
        drain_results();

        // Final header fault: the block must stop and swallow the rest
        fault = header_fault_t'($urandom_range(4));
        mf    = $urandom_range(65534);
        lo    = $urandom_range(1, 200);
        hi    = lo + $urandom_range(54);
        if (fault == MINOR_BOUNDS_CROSSED)
        begin
            lo = $urandom_range(1, 255);
            hi = $urandom_range(lo - 1);
        end
        configure(mf, lo, hi, 0);
        ctype = 8'(TYPE_FIRST + $urandom_range(3));
        major = REQUIRED_MAJOR;
        minor = 8'($urandom_range(lo, hi));
        len   = $urandom_range(mf);
        case (fault)
            BAD_TYPE:
            begin
                do
                    ctype = 8'($urandom_range(255));
                while (ctype inside {[TYPE_FIRST:TYPE_LAST]});
                len = $urandom_range(65535);
            end
            BAD_MAJOR:
            begin
                do
                    major = 8'($urandom_range(255));
                while (major == REQUIRED_MAJOR);
                len = $urandom_range(65535);
            end
            MINOR_OUT:
            begin
                if ($urandom_range(1) == 1)
                    minor = 8'($urandom_range(lo - 1));
                else
                    minor = 8'($urandom_range(hi + 1, 255));
            end
            MINOR_BOUNDS_CROSSED:
                minor = 8'($urandom_range(255));
            default:
                len = $urandom_range(mf + 1, 65535);
        endcase
        send_header(ctype, major, minor, 16'(len));
        repeat (20) send_byte(8'($urandom_range(255)));
        drain_results();

        if (sb.pending.size() != 0)
            sb.mismatches++;
        $display("run covered %0d stream bytes in %0d good records and %0d result beats",
                 sb.bytes_seen, records_sent, sb.results_seen);
        $display("five register settings, then fault %s: %0d error beat(s), code %0d",
                 fault.name(), sb.errors_seen, sb.last_error);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
